// ===== hw/rtl/aabc_pkg.sv =====
package aabc_pkg;

  // Register map: index of each configuration register (byte address 4*index)
  localparam int unsigned RegCount  = 2;
  localparam int unsigned AddrWidth = 3;
  localparam logic REG_SURFACE_WIDTH  = 1'b0;
  localparam logic REG_SURFACE_HEIGHT = 1'b1;

  localparam int unsigned DimWidth = 13;
  localparam logic [DimWidth-1:0] SurfaceWidthReset  = 13'd1600;
  localparam logic [DimWidth-1:0] SurfaceHeightReset = 13'd900;

  localparam logic [7:0] ChMax = 8'hFF;

  localparam int unsigned InDataWidth  = 88;
  localparam int unsigned OutDataWidth = 32;

  // Clipping window
  typedef struct packed {
    logic [DimWidth-1:0] surface_height;
    logic [DimWidth-1:0] surface_width;
  } aabc_cfg_t;

  // One input beat, unpacked
  typedef struct packed {
    logic        blend_mode;
    logic [11:0] pos_y;
    logic [11:0] pos_x;
    logic [31:0] bg_pixel;
    logic [31:0] fg_pixel;
  } aabc_item_t;

  // One result beat
  typedef struct packed {
    logic        write_enable;
    logic [31:0] out_pixel;
  } aabc_result_t;

  // Exact floor(x / 255) for x <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== hw/rtl/argb_alpha_blend_compositor_unit.sv =====
// ARGB8888 source-over compositing unit.
// Input stream (s_axis_*): one beat per pixel carrying the layer pixel, the
// back-buffer pixel at the same place, its column and row, and the layer's
// blend mode in tuser. Output stream (m_axis_*): one beat per input beat with
// the pixel to store in tdata and its write enable in tuser.
// The clipping window is set over the APB port: surface width at 0x0,
// surface height at 0x4, 13 bits each; write them only while no beat is in
// flight.
// An input register feeds the blend datapath (three 8x8 multiplier pairs and a
// divide-by-255 adder per channel), whose result lands in the output register.
// Throughput is one pixel per clock while m_axis_tready stays high; the two
// registers form a pipeline whose ready is passed back a stage at a time, so a
// new beat is taken while a finished result still waits for the receiver.
// When the receiver holds m_axis_tready low, the output register holds its
// beat, the input register fills, and s_axis_tready drops until space frees.
// Reset empties both registers and loads width 1600 and height 900.
module argb_alpha_blend_compositor_unit
  import aabc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // APB configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Pixel input
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,  // fg_pixel, bg_pixel, pos_x, pos_y
  input  logic                    s_axis_tuser,  // blend_mode
  // Pixel output
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,  // out_pixel
  output logic                    m_axis_tuser   // write_enable
);

  aabc_cfg_t    cfg;
  aabc_item_t   s1_item_q;
  logic         s1_valid_q;
  aabc_result_t s2_res_q;
  aabc_result_t blend_res;
  logic         s2_valid_q;
  logic         s1_ready;
  logic         s2_ready;
  logic         in_beat;

  aabc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s2_ready      = !s2_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_beat       = s_axis_tvalid && s1_ready;

  // Input register: capture a beat when the stage frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_item_q <= {s_axis_tuser, s_axis_tdata};
    end
  end

  aabc_blend u_blend (
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (blend_res)
  );

  // Output register: advance when the receiver takes the beat or it is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_res_q <= blend_res;
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = s2_res_q.out_pixel;
  assign m_axis_tuser  = s2_res_q.write_enable;

  // An accepted beat occupies the input register next cycle
  a_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> s1_valid_q)
    else $error("accepted beat lost before input register");

  // A blocked input register keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_item_q))
    else $error("input register changed while blocked");

  // An item that moves on reaches the output register
  a_s2_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> s2_valid_q)
    else $error("item lost between stages");

endmodule

// ===== hw/rtl/aabc_cfg_regs.sv =====
module aabc_cfg_regs
  import aabc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output aabc_cfg_t            cfg_o
);

  logic [DimWidth-1:0] width_q, width_d;
  logic [DimWidth-1:0] height_q, height_d;
  logic                wr_en;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Decode the write beat
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SURFACE_WIDTH:  width_d  = pwdata[DimWidth-1:0];
        REG_SURFACE_HEIGHT: height_d = pwdata[DimWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SurfaceWidthReset;
      height_q <= SurfaceHeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_SURFACE_WIDTH:  prdata = {{(32-DimWidth){1'b0}}, width_q};
      REG_SURFACE_HEIGHT: prdata = {{(32-DimWidth){1'b0}}, height_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.surface_width  = width_q;
  assign cfg_o.surface_height = height_q;

endmodule

// ===== hw/rtl/aabc_blend.sv =====
module aabc_blend
  import aabc_pkg::*;
(
  input  aabc_item_t   item_i,
  input  aabc_cfg_t    cfg_i,
  output aabc_result_t result_o
);

  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [7:0]  mix [3];
  logic [31:0] blended;
  logic        inside_surf;

  assign alpha     = item_i.fg_pixel[31:24];
  assign inv_alpha = ChMax - alpha;

  // Mix each color channel: (f*a + b*(255-a)) / 255
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [15:0] prod_f;
    logic [15:0] prod_b;
    logic [15:0] sum;
    assign prod_f = item_i.fg_pixel[8*c +: 8] * alpha;
    assign prod_b = item_i.bg_pixel[8*c +: 8] * inv_alpha;
    assign sum    = prod_f + prod_b;
    assign mix[c] = div255(sum);
  end

  // Pick pass-through on the alpha extremes
  always_comb begin
    if (alpha == ChMax) begin
      blended = item_i.fg_pixel;
    end else if (alpha == 8'd0) begin
      blended = item_i.bg_pixel;
    end else begin
      blended = {ChMax, mix[2], mix[1], mix[0]};
    end
  end

  // Clip against the surface
  assign inside_surf = ({1'b0, item_i.pos_x} < cfg_i.surface_width) &&
                       ({1'b0, item_i.pos_y} < cfg_i.surface_height);

  always_comb begin
    result_o.out_pixel    = item_i.bg_pixel;
    result_o.write_enable = 1'b0;
    if (inside_surf) begin
      if (item_i.blend_mode) begin
        result_o.out_pixel    = blended;
        result_o.write_enable = 1'b1;
      end else if (alpha != 8'd0) begin
        result_o.out_pixel    = item_i.fg_pixel;
        result_o.write_enable = 1'b1;
      end
    end
  end

endmodule
